// File: rtl/vtdi_pkg.sv
// ----------------------------------------------------------------------------
// vtdi_pkg: shared types and constants of the vertex tuple dedup indexer
// Table sizing, field widths and the item types passed between the front
// queue and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vtdi_pkg;

  // table sizing
  localparam int MAX_VERTICES = 1024;
  localparam int INDEX_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);

  // port field widths
  localparam int FIELD_BITS   = 16;
  localparam int VINDEX_BITS  = 10;
  localparam int COMP_BITS    = 2;

  // component count codes
  localparam logic [COMP_BITS-1:0] COMP_POS_ONLY = 2'd1;
  localparam logic [COMP_BITS-1:0] COMP_POS_TEX  = 2'd2;
  localparam logic [COMP_BITS-1:0] COMP_ALL      = 2'd3;

  // stored tuple, position in the low bits
  typedef struct packed {
    logic [INDEX_BITS-1:0] normal;
    logic [INDEX_BITS-1:0] texcoord;
    logic [INDEX_BITS-1:0] position;
  } tuple_t;

  localparam int TUPLE_BITS = $bits(tuple_t);

  // one queued corner
  typedef struct packed {
    logic   start_of_mesh;
    tuple_t tuple;
  } queue_entry_t;

  // queue head status toward the back end
  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  // back end handshake toward the queue
  typedef struct packed {
    logic pop;
  } queue_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/vtdi_ifs.sv
// ----------------------------------------------------------------------------
// vtdi channel interfaces
// Valid/ready channels for corners, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtdi_corner_if;
  logic                             valid;
  logic                             ready;
  logic                             start_of_mesh;
  logic [vtdi_pkg::FIELD_BITS-1:0]  position_index;
  logic [vtdi_pkg::FIELD_BITS-1:0]  texcoord_index;
  logic [vtdi_pkg::FIELD_BITS-1:0]  normal_index;

  modport source (output valid, output start_of_mesh, output position_index,
                  output texcoord_index, output normal_index, input ready);
  modport sink   (input valid, input start_of_mesh, input position_index,
                  input texcoord_index, input normal_index, output ready);
endinterface

interface vtdi_result_if;
  logic                             valid;
  logic                             ready;
  logic [vtdi_pkg::VINDEX_BITS-1:0] vertex_index;
  logic                             is_new;
  logic                             overflow;

  modport source (output valid, output vertex_index, output is_new,
                  output overflow, input ready);
  modport sink   (input valid, input vertex_index, input is_new,
                  input overflow, output ready);
endinterface

interface vtdi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vtdi_pkg::COMP_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/vtdi_front.sv
// ----------------------------------------------------------------------------
// vtdi_front: corner intake and two-entry queue
// Accepts corners, casts each component to the table width and holds them
// until the search engine takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module vtdi_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  vtdi_corner_if.sink                corner,
  output vtdi_pkg::queue_head_t      head,
  input  vtdi_pkg::queue_ctrl_t      ctrl
);

  vtdi_pkg::queue_entry_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  vtdi_pkg::queue_entry_t in_entry;

  // build the queued item from the port fields
  always_comb begin
    in_entry.start_of_mesh  = corner.start_of_mesh;
    in_entry.tuple.position = vtdi_pkg::INDEX_BITS'(corner.position_index);
    in_entry.tuple.texcoord = vtdi_pkg::INDEX_BITS'(corner.texcoord_index);
    in_entry.tuple.normal   = vtdi_pkg::INDEX_BITS'(corner.normal_index);
  end

  assign corner.ready = (fill != 2'd2);
  assign push         = corner.valid && corner.ready;
  assign pop          = ctrl.pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.entry = slot[rd_ptr];

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/vtdi_back.sv
// ----------------------------------------------------------------------------
// vtdi_back: tuple table search and insert engine
// Scans the stored tuples one entry per read, returns the first match, or
// appends the tuple, or flags overflow when the table is full; results sit in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtdi_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  vtdi_pkg::queue_head_t            head,
  output vtdi_pkg::queue_ctrl_t            ctrl,
  input  wire logic [vtdi_pkg::COMP_BITS-1:0] comp_in_use,
  vtdi_result_if.source                    result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DEC  = 4'b1000
  } state_t;

  localparam logic [vtdi_pkg::COMP_BITS-1:0] COMP_ALL_C = vtdi_pkg::COMP_ALL;
  localparam logic [vtdi_pkg::COMP_BITS-1:0] COMP_TEX_C = vtdi_pkg::COMP_POS_TEX;

  state_t                            state;
  logic [vtdi_pkg::COUNT_BITS-1:0]   count;
  logic [vtdi_pkg::ADDR_BITS-1:0]    idx;
  vtdi_pkg::tuple_t                  tuple;

  logic [vtdi_pkg::TUPLE_BITS-1:0]   mem [vtdi_pkg::MAX_VERTICES];
  vtdi_pkg::tuple_t                  rd_data;
  logic                              rd_en;
  logic                              mem_we;

  logic                              emit;
  logic                              match;
  logic                              last_entry;
  logic                              full;
  logic [vtdi_pkg::COUNT_BITS-1:0]   count_eff;

  logic                              out_valid;
  logic [vtdi_pkg::VINDEX_BITS-1:0]  out_vindex;
  logic                              out_new;
  logic                              out_ovf;

  // component compare, count 0 behaves as 1
  always_comb begin
    logic pos_eq;
    logic tex_eq;
    logic nrm_eq;
    pos_eq = (rd_data.position == tuple.position);
    tex_eq = (rd_data.texcoord == tuple.texcoord);
    nrm_eq = (rd_data.normal   == tuple.normal);
    case (comp_in_use)
      COMP_ALL_C:  match = pos_eq && tex_eq && nrm_eq;
      COMP_TEX_C:  match = pos_eq && tex_eq;
      default:     match = pos_eq;
    endcase
  end

  assign emit       = !out_valid || result.ready;
  assign last_entry = ({1'b0, idx} + vtdi_pkg::COUNT_BITS'(1)) == count;
  assign full       = (count == vtdi_pkg::COUNT_BITS'(vtdi_pkg::MAX_VERTICES));
  assign count_eff  = head.entry.start_of_mesh ? '0 : count;
  assign rd_en      = (state == S_RD);
  assign mem_we     = (state == S_DEC) && emit && !full;
  assign ctrl.pop   = (state == S_IDLE) && head.valid;

  // tuple table, only entries below count are ever read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[vtdi_pkg::ADDR_BITS-1:0]] <= tuple;
    end
    if (rd_en) begin
      rd_data <= mem[idx];
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            count <= count_eff;
            idx   <= '0;
            state <= (count_eff == '0) ? S_DEC : S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (match) begin
            if (emit) state <= S_IDLE;
          end else if (last_entry) begin
            state <= S_DEC;
          end else begin
            idx   <= idx + vtdi_pkg::ADDR_BITS'(1);
            state <= S_RD;
          end
        end
        S_DEC: begin
          if (emit) begin
            if (!full) count <= count + vtdi_pkg::COUNT_BITS'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latch the tuple of the item taken from the queue
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      tuple <= head.entry.tuple;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_CMP) && match && emit) begin
      out_valid <= 1'b1;
    end else if ((state == S_DEC) && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_CMP) && match && emit) begin
      out_vindex <= vtdi_pkg::VINDEX_BITS'(idx);
      out_new    <= 1'b0;
      out_ovf    <= 1'b0;
    end else if ((state == S_DEC) && emit) begin
      out_vindex <= full ? '0 : vtdi_pkg::VINDEX_BITS'(count);
      out_new    <= !full;
      out_ovf    <= full;
    end
  end

  assign result.valid        = out_valid;
  assign result.vertex_index = out_vindex;
  assign result.is_new       = out_new;
  assign result.overflow     = out_ovf;

endmodule

`default_nettype wire

// File: rtl/vertex_tuple_dedup_indexer_unit.sv
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_indexer_unit: vertex tuple deduplicating indexer
// Gives each distinct (position, texcoord, normal) corner tuple a vertex
// number in order of first appearance since the last start of mesh.
// ----------------------------------------------------------------------------
// Usage:
//   corner : one face corner per item; start_of_mesh empties the table first.
//   result : one item per corner: vertex_index, is_new, overflow.
//   cfg    : writes components_in_use (1..3, 0 acts as 1); write only while
//            the block is idle. Always ready.
// Timing:
//   A two-entry queue takes corners while the engine works. The engine scans
//   the stored tuples through the single table port, each entry in a read
//   state and then a compare state. A scan covers at most the distinct count
//   (at most 1024), stops at the first hit, and on a miss ends in a decide
//   state that appends one entry unless the table is full.
//   The next queued corner starts in the cycle after a result is registered.
// Reset:
//   Clears the distinct count, the queue and the output register; sets
//   components_in_use to 3. The table needs no clearing pass.
// Stall:
//   The result register holds while result.ready is low; the engine waits
//   with its finished item, and the queue fills and drops corner.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_tuple_dedup_indexer_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  vtdi_corner_if.sink  corner,
  vtdi_result_if.source result,
  vtdi_cfg_if.sink     cfg
);

  vtdi_pkg::queue_head_t              head;
  vtdi_pkg::queue_ctrl_t              ctrl;
  logic [vtdi_pkg::COMP_BITS-1:0]     comp_in_use;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_in_use <= vtdi_pkg::COMP_ALL;
    end else if (cfg.valid && cfg.ready) begin
      comp_in_use <= cfg.data;
    end
  end

  vtdi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .corner (corner),
    .head   (head),
    .ctrl   (ctrl)
  );

  vtdi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .ctrl        (ctrl),
    .comp_in_use (comp_in_use),
    .result      (result)
  );

  // checks
  a_new_not_ovf: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.is_new && result.overflow))
    else $error("is_new and overflow both set");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.overflow) |-> (result.vertex_index == '0))
    else $error("overflow result with nonzero vertex index");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (comp_in_use == $past(cfg.data)))
    else $error("component count write lost");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (head.valid && !ctrl.pop) |=> head.valid)
    else $error("queued item vanished without a pop");

endmodule

`default_nettype wire
